// ===== hdl/fqd_pkg.sv =====
package fqd_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned LenW      = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    CmdEnq = 2'd0,
    CmdDeq = 2'd1,
    CmdDel = 2'd2
  } cmd_e;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                 deq;
    logic                 del;
    logic                 enq;
    logic [DataWidth-1:0] word;
  } ctl_t;

endpackage

// ===== hdl/fqd_cell.sv =====
module fqd_cell (
  input  logic                          clk_i,
  input  fqd_pkg::ctl_t                 ctl_i,
  input  logic                          occ_i,
  input  logic                          tail_i,
  input  logic                          hit_i,
  input  logic [fqd_pkg::DataWidth-1:0] data_nxt_i,
  output logic [fqd_pkg::DataWidth-1:0] data_o,
  output logic                          hit_o
);

  logic [fqd_pkg::DataWidth-1:0] data_q, data_d;
  logic                          shift;

  // hit_o is set once a matching entry sits here or closer to the head.
  assign hit_o = hit_i | (occ_i & (data_q == ctl_i.word));
  assign shift = ctl_i.deq | (ctl_i.del & hit_o);

  always_comb begin
    data_d = data_q;
    if (shift) begin
      data_d = data_nxt_i;
    end else if (ctl_i.enq && tail_i) begin
      data_d = ctl_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hdl/fqd_ctrl.sv =====
module fqd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [31:0]                   value_i,
  input  logic [fqd_pkg::DataWidth-1:0] head_i,
  input  logic                          any_hit_i,
  output fqd_pkg::ctl_t                 ctl_o,
  output logic [fqd_pkg::LenW-1:0]      count_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [31:0]                   data_o,
  output logic [fqd_pkg::LenW-1:0]      len_o
);

  logic [fqd_pkg::LenW-1:0]      count_q, count_d;
  logic                          out_valid_q;
  logic                          status_q;
  logic [31:0]                   data_q;
  logic [fqd_pkg::LenW-1:0]      len_q;
  logic [fqd_pkg::DataWidth-1:0] word;
  logic                          fire, nonzero, empty, full;
  logic                          enq_ok, deq_ok, del_req, del_ok, ok;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign word       = value_i[fqd_pkg::DataWidth-1:0];
  assign nonzero    = (word != '0);
  assign empty      = (count_q == '0);
  assign full       = (count_q == fqd_pkg::LenW'(fqd_pkg::Depth));

  always_comb begin
    enq_ok  = 1'b0;
    deq_ok  = 1'b0;
    del_req = 1'b0;
    case (fqd_pkg::cmd_e'(cmd_i))
      fqd_pkg::CmdEnq: enq_ok  = fire && nonzero && !full;
      fqd_pkg::CmdDeq: deq_ok  = fire && !empty;
      fqd_pkg::CmdDel: del_req = fire && nonzero;
      default: ;
    endcase
  end

  // Without a match no cell shifts, so the request itself can drive the chain.
  assign del_ok = del_req && any_hit_i;
  assign ok     = enq_ok || deq_ok || del_ok;

  assign ctl_o.deq  = deq_ok;
  assign ctl_o.del  = del_req;
  assign ctl_o.enq  = enq_ok;
  assign ctl_o.word = word;

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + 1'b1;
    end else if (deq_ok || del_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= !ok;
      data_q   <= deq_ok ? 32'(head_i) : 32'd0;
      len_q    <= count_d;
    end
  end

  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign len_o       = len_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fqd_pkg::LenW'(fqd_pkg::Depth))
    else $error("queue length exceeds depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> (count_q == $past(count_q) + 1'b1))
    else $error("successful enqueue did not grow the queue");

  a_deq_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_ok |=> (data_q == 32'($past(head_i))) && !status_q)
    else $error("dequeue did not return the head word");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q) |-> (data_q == 32'd0))
    else $error("error result carries data");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && (len_q == count_q))
    else $error("result missing or length mismatch");

endmodule

// ===== hdl/fifo_queue_with_delete_top.sv =====
// Channel   Dir  tdata (low bit up)                       tuser
// s_axis    in   value[31:0]                              cmd[1:0]
// m_axis    out  data_out[31:0], length[36:32], pad zero  status[0]
//
// One command is taken per cycle; its result word is registered for the next cycle.
// The cell chain compares every entry and shifts in the same cycle as the command.
// A new command is taken while the result register is empty or being read.
// Reset (rst_ni low) empties the queue at once; entry contents are left as they are.
// A stall on m_axis holds the result and stalls s_axis until it is taken.
module fifo_queue_with_delete_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // data_out[31:0], length[36:32], zeros
  output logic [0:0]  m_axis_tuser    // status[0]
);

  localparam int unsigned Depth = fqd_pkg::Depth;

  fqd_pkg::ctl_t                 ctl;
  logic [fqd_pkg::LenW-1:0]      count;
  logic [fqd_pkg::LenW-1:0]      len;
  logic [31:0]                   data_out;
  logic                          status;
  logic [fqd_pkg::DataWidth-1:0] cell_data [Depth];
  logic [Depth:0]                hit_chain;

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [fqd_pkg::DataWidth-1:0] nxt;
    logic                          occ, tail;

    if (i == Depth - 1) begin : g_last
      assign nxt = cell_data[i];
    end else begin : g_mid
      assign nxt = cell_data[i+1];
    end

    assign occ  = (fqd_pkg::LenW'(i) < count);
    assign tail = (fqd_pkg::LenW'(i) == count);

    fqd_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occ_i      (occ),
      .tail_i     (tail),
      .hit_i      (hit_chain[i]),
      .data_nxt_i (nxt),
      .data_o     (cell_data[i]),
      .hit_o      (hit_chain[i+1])
    );
  end

  fqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .head_i      (cell_data[0]),
    .any_hit_i   (hit_chain[Depth]),
    .ctl_o       (ctl),
    .count_o     (count),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .data_o      (data_out),
    .len_o       (len)
  );

  assign m_axis_tdata = 40'({len, data_out});
  assign m_axis_tuser = status;

endmodule
